FILE: sv/wpik_pkg.sv
// ----------------------------------------------------------------------------
// wpik_pkg
// Shared types, constants and codes of the wall plotter inverse kinematics.
// ----------------------------------------------------------------------------
package wpik_pkg;

  localparam int MAX_SEGMENTS_DEF  = 64;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF   = 2;

  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_X  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_Y  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_X = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_Y = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEG_LEN = 3'd4;

  localparam logic OP_MOVE = 1'b0;
  localparam logic OP_HOME = 1'b1;

  localparam int MAG_W     = 33;
  localparam int DIST_W    = 34;
  localparam int SQ_ARG_W  = 68;
  localparam int SQ_ROOT_W = 34;
  localparam int SQ_REM_W  = 37;
  localparam int SQ_STEPS  = 34;
  localparam int DV_NUM_W  = 65;
  localparam int DV_DEN_W  = 35;
  localparam int DV_REM_W  = 36;
  localparam int DV_STEPS  = 65;
  localparam int CNT_W     = 7;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic               rapid;
    logic [31:0]        base_feed;
  } item_t;

  typedef struct packed {
    logic [31:0]        left_length;
    logic [31:0]        right_length;
    logic signed [31:0] z_position;
    logic [31:0]        segment_feed;
    logic               last_segment;
  } result_t;

  // classified move: flags, start point, delta magnitudes and signs, base feed
  typedef struct packed {
    logic               home;
    logic               rapid;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic [MAG_W-1:0]   mx;
    logic [MAG_W-1:0]   my;
    logic [MAG_W-1:0]   mz;
    logic               nx;
    logic               ny;
    logic               nz;
    logic [31:0]        base;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic signed [31:0] lax;
    logic signed [31:0] lay;
    logic signed [31:0] rax;
    logic signed [31:0] ray;
    logic [30:0]        seg;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DSQX, ST_DSQY, ST_DSQZ, ST_DROOT, ST_COUNT,
    ST_DIVD, ST_DIVX, ST_DIVY, ST_DIVZ, ST_STEP,
    ST_LSQX, ST_LSQY, ST_LROOT, ST_RSQX, ST_RSQY, ST_RROOT,
    ST_FMUL, ST_FDIV, ST_EMIT
  } state_t;

endpackage

FILE: sv/wpik_front.sv
// ----------------------------------------------------------------------------
// wpik_front
// Accepts input beats, classifies them and forms move deltas for the queue.
// ----------------------------------------------------------------------------
module wpik_front (
  input  logic              item_valid,
  output logic              item_stall,
  input  wpik_pkg::item_t   item,
  input  wpik_pkg::q_stat_t qstat,
  output logic              push,
  output wpik_pkg::job_t    job
);
  import wpik_pkg::*;

  logic signed [32:0] dx, dy, dz;

  assign item_stall = qstat.full;
  assign push       = item_valid && !qstat.full;

  always_comb begin
    dx = {item.target_x[31], item.target_x} - {item.start_x[31], item.start_x};
    dy = {item.target_y[31], item.target_y} - {item.start_y[31], item.start_y};
    dz = {item.target_z[31], item.target_z} - {item.start_z[31], item.start_z};
    job.home  = (item.operation == OP_HOME);
    job.rapid = item.rapid;
    job.sx    = item.start_x;
    job.sy    = item.start_y;
    job.sz    = item.start_z;
    job.nx    = dx[32];
    job.ny    = dy[32];
    job.nz    = dz[32];
    job.mx    = dx[32] ? MAG_W'(-dx) : MAG_W'(dx);
    job.my    = dy[32] ? MAG_W'(-dy) : MAG_W'(dy);
    job.mz    = dz[32] ? MAG_W'(-dz) : MAG_W'(dz);
    job.base  = item.base_feed;
  end

endmodule

FILE: sv/wpik_queue.sv
// ----------------------------------------------------------------------------
// wpik_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module wpik_queue #(
  parameter int DEPTH = wpik_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  wpik_pkg::job_t    wdata,
  input  logic              pop,
  output wpik_pkg::job_t    rdata,
  output wpik_pkg::q_stat_t qstat
);
  import wpik_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [CW-1:0] count;

  assign rdata       = mem[rp];
  assign qstat.full  = (count == CW'(DEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

FILE: sv/wpik_back.sv
// ----------------------------------------------------------------------------
// wpik_back
// Segment sequencer: move length, segment count, interpolation, cord lengths
// and feed, on one shared square root unit and one shared divider.
// ----------------------------------------------------------------------------
module wpik_back #(
  parameter int MAX_SEGMENTS = wpik_pkg::MAX_SEGMENTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  wpik_pkg::q_stat_t qstat,
  input  wpik_pkg::job_t    job,
  output logic              pop,
  input  wpik_pkg::cfg_t    cfg,
  output logic              result_valid,
  input  logic              result_stall,
  output wpik_pkg::result_t result
);
  import wpik_pkg::*;

  localparam int NW = $clog2(MAX_SEGMENTS + 1);

  state_t              state, state_next;
  logic [CNT_W-1:0]    cnt;
  job_t                jb;
  logic [DIST_W-1:0]   move_len, d;
  logic [NW-1:0]       n, k;
  logic [35:0]         acc;
  logic [MAG_W-1:0]    qv [3];
  logic [NW-1:0]       rv [3];
  logic [MAG_W-1:0]    aq [3];
  logic [NW-1:0]       ar [3];
  logic [MAG_W-1:0]    aq_next [3];
  logic [NW-1:0]       ar_next [3];
  logic [31:0]         prev_l, prev_r, ll, rl, feed;
  logic [SQ_ARG_W-1:0] sq_arg;
  logic [SQ_REM_W-1:0] sq_rem;
  logic [SQ_ROOT_W-1:0] sq_root;
  logic [DV_NUM_W-1:0] dv_num, dv_quo;
  logic [DV_REM_W-1:0] dv_rem;
  logic [DV_DEN_W-1:0] dv_den;

  // step logic of the shared units
  logic [SQ_REM_W-1:0]  rem_sh, trial, sq_rem_n;
  logic                 sq_ge, sq_last;
  logic [SQ_ROOT_W-1:0] sq_root_n;
  logic [DV_REM_W-1:0]  dv_sh, dv_rem_n;
  logic                 dv_ge, dv_last;
  logic [DV_NUM_W-1:0]  dv_quo_n;

  logic [30:0]          seg_eff;
  logic signed [31:0]   px, py, pz;
  logic [MAG_W-1:0]     sq_op;
  logic [65:0]          square;
  logic signed [32:0]   dl, dr;
  logic signed [33:0]   s;
  logic                 feed_plain, feed_half, out_load;
  logic [64:0]          prod;

  function automatic logic signed [31:0] place(input logic signed [31:0] st,
                                               input logic neg,
                                               input logic [MAG_W-1:0] m);
    logic signed [33:0] off, p;
    off = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    p   = {{2{st[31]}}, st} + off;
    return p[31:0];
  endfunction

  function automatic logic [MAG_W-1:0] gap(input logic signed [31:0] p,
                                           input logic signed [31:0] a);
    logic signed [32:0] t;
    t = {p[31], p} - {a[31], a};
    return t[32] ? MAG_W'(-t) : MAG_W'(t);
  endfunction

  assign seg_eff = (cfg.seg == '0) ? 31'd1 : cfg.seg;

  assign rem_sh    = {sq_rem[34:0], sq_arg[SQ_ARG_W-1 -: 2]};
  assign trial     = {1'b0, sq_root, 2'b01};
  assign sq_ge     = (rem_sh >= trial);
  assign sq_rem_n  = sq_ge ? rem_sh - trial : rem_sh;
  assign sq_root_n = {sq_root[SQ_ROOT_W-2:0], sq_ge};
  assign sq_last   = (cnt == CNT_W'(SQ_STEPS - 1));

  assign dv_sh    = {dv_rem[DV_REM_W-2:0], dv_num[DV_NUM_W-1]};
  assign dv_ge    = (dv_sh >= {1'b0, dv_den});
  assign dv_rem_n = dv_ge ? dv_sh - {1'b0, dv_den} : dv_sh;
  assign dv_quo_n = {dv_quo[DV_NUM_W-2:0], dv_ge};
  assign dv_last  = (cnt == CNT_W'(DV_STEPS - 1));

  assign px = place(jb.sx, jb.nx, aq[0]);
  assign py = place(jb.sy, jb.ny, aq[1]);
  assign pz = place(jb.sz, jb.nz, aq[2]);

  always_comb begin
    case (state)
      ST_DSQX: sq_op = jb.mx;
      ST_DSQY: sq_op = jb.my;
      ST_DSQZ: sq_op = jb.mz;
      ST_LSQX: sq_op = gap(px, cfg.lax);
      ST_LSQY: sq_op = gap(py, cfg.lay);
      ST_RSQX: sq_op = gap(px, cfg.rax);
      ST_RSQY: sq_op = gap(py, cfg.ray);
      default: sq_op = '0;
    endcase
    square = sq_op * sq_op;
  end

  // remainder stepping of k * delta / n, one segment at a time
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [NW:0] t;
      t = {1'b0, ar[i]} + {1'b0, rv[i]};
      if (t >= {1'b0, n}) begin
        aq_next[i] = aq[i] + qv[i] + 1'b1;
        ar_next[i] = NW'(t - {1'b0, n});
      end else begin
        aq_next[i] = aq[i] + qv[i];
        ar_next[i] = t[NW-1:0];
      end
    end
  end

  always_comb begin
    dl         = $signed({1'b0, ll}) - $signed({1'b0, prev_l});
    dr         = $signed({1'b0, rl}) - $signed({1'b0, prev_r});
    s          = {dl[32], dl} + {dr[32], dr};
    feed_plain = (dl == '0 && dr == '0) || (d == '0);
    feed_half  = $signed({s[33], s}) < $signed({1'b0, d});
    prod       = jb.base * s[32:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (!qstat.empty) state_next = job.home ? ST_IDLE : ST_DSQX;
      ST_DSQX:  state_next = ST_DSQY;
      ST_DSQY:  state_next = ST_DSQZ;
      ST_DSQZ:  state_next = ST_DROOT;
      ST_DROOT: if (sq_last) state_next = ST_COUNT;
      ST_COUNT: begin
        if (jb.rapid || acc >= {2'b0, move_len} || n >= NW'(MAX_SEGMENTS))
          state_next = ST_DIVD;
      end
      ST_DIVD:  if (dv_last) state_next = ST_DIVX;
      ST_DIVX:  if (dv_last) state_next = ST_DIVY;
      ST_DIVY:  if (dv_last) state_next = ST_DIVZ;
      ST_DIVZ:  if (dv_last) state_next = ST_STEP;
      ST_STEP:  state_next = ST_LSQX;
      ST_LSQX:  state_next = ST_LSQY;
      ST_LSQY:  state_next = ST_LROOT;
      ST_LROOT: if (sq_last) state_next = ST_RSQX;
      ST_RSQX:  state_next = ST_RSQY;
      ST_RSQY:  state_next = ST_RROOT;
      ST_RROOT: if (sq_last) state_next = ST_FMUL;
      ST_FMUL:  state_next = (feed_plain || feed_half) ? ST_EMIT : ST_FDIV;
      ST_FDIV:  if (dv_last) state_next = ST_EMIT;
      ST_EMIT:  if (out_load) state_next = (k == n) ? ST_IDLE : ST_STEP;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop      = (state == ST_IDLE) && !qstat.empty;
    out_load = (state == ST_EMIT) && (!result_valid || !result_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      prev_l       <= '0;
      prev_r       <= '0;
    end else begin
      state <= state_next;
      if (out_load)          result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
      if (pop && job.home) begin
        prev_l <= '0;
        prev_r <= '0;
      end
      if (out_load) begin
        prev_l <= ll;
        prev_r <= rl;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt     <= cnt + 1'b1;
    sq_arg  <= {sq_arg[SQ_ARG_W-3:0], 2'b00};
    sq_rem  <= sq_rem_n;
    sq_root <= sq_root_n;
    dv_num  <= {dv_num[DV_NUM_W-2:0], 1'b0};
    dv_rem  <= dv_rem_n;
    dv_quo  <= dv_quo_n;
    case (state)
      ST_IDLE: begin
        jb     <= job;
        sq_arg <= '0;
      end
      ST_DSQX, ST_DSQY, ST_LSQX, ST_RSQX: begin
        sq_arg <= sq_arg + SQ_ARG_W'(square);
      end
      ST_DSQZ, ST_LSQY, ST_RSQY: begin
        sq_arg  <= sq_arg + SQ_ARG_W'(square);
        sq_rem  <= '0;
        sq_root <= '0;
        cnt     <= '0;
      end
      ST_DROOT: begin
        if (sq_last) begin
          move_len <= sq_root_n;
          acc      <= 36'(seg_eff);
          n        <= NW'(1);
        end
      end
      ST_COUNT: begin
        if (state_next == ST_COUNT) begin
          acc <= acc + 36'(seg_eff);
          n   <= n + 1'b1;
        end else begin
          dv_num <= DV_NUM_W'(move_len);
          dv_den <= DV_DEN_W'(n);
          dv_rem <= '0;
          dv_quo <= '0;
          cnt    <= '0;
        end
      end
      ST_DIVD, ST_DIVX, ST_DIVY, ST_DIVZ: begin
        if (dv_last) begin
          dv_rem <= '0;
          dv_quo <= '0;
          cnt    <= '0;
          case (state)
            ST_DIVD: begin
              d      <= dv_quo_n[DIST_W-1:0];
              dv_num <= DV_NUM_W'(jb.mx);
            end
            ST_DIVX: begin
              qv[0]  <= dv_quo_n[MAG_W-1:0];
              rv[0]  <= dv_rem_n[NW-1:0];
              dv_num <= DV_NUM_W'(jb.my);
            end
            ST_DIVY: begin
              qv[1]  <= dv_quo_n[MAG_W-1:0];
              rv[1]  <= dv_rem_n[NW-1:0];
              dv_num <= DV_NUM_W'(jb.mz);
            end
            default: begin
              qv[2] <= dv_quo_n[MAG_W-1:0];
              rv[2] <= dv_rem_n[NW-1:0];
              for (int i = 0; i < 3; i++) begin
                aq[i] <= '0;
                ar[i] <= '0;
              end
              k <= '0;
            end
          endcase
        end
      end
      ST_STEP: begin
        for (int i = 0; i < 3; i++) begin
          aq[i] <= aq_next[i];
          ar[i] <= ar_next[i];
        end
        k      <= k + 1'b1;
        sq_arg <= '0;
      end
      ST_LROOT: begin
        if (sq_last) begin
          ll     <= (|sq_root_n[SQ_ROOT_W-1:32]) ? '1 : sq_root_n[31:0];
          sq_arg <= '0;
        end
      end
      ST_RROOT: begin
        if (sq_last) rl <= (|sq_root_n[SQ_ROOT_W-1:32]) ? '1 : sq_root_n[31:0];
      end
      ST_FMUL: begin
        if (feed_plain)     feed <= jb.base;
        else if (feed_half) feed <= {1'b0, jb.base[31:1]};
        dv_num <= prod;
        dv_den <= {d, 1'b0};
        dv_rem <= '0;
        dv_quo <= '0;
        cnt    <= '0;
      end
      ST_FDIV: begin
        if (dv_last) feed <= (|dv_quo_n[DV_NUM_W-1:32]) ? '1 : dv_quo_n[31:0];
      end
      default: begin
      end
    endcase
    if (out_load) begin
      result.left_length  <= ll;
      result.right_length <= rl;
      result.z_position   <= pz;
      result.segment_feed <= feed;
      result.last_segment <= (k == n);
    end
  end

endmodule

FILE: sv/wall_plotter_inverse_kinematics_unit.sv
// ----------------------------------------------------------------------------
// wall_plotter_inverse_kinematics_unit
// Each segment takes two 34-step square roots on the shared units, and a 65-step
// division when the feed needs it; move setup is one 34-step root, up to
// MAX_SEGMENTS count steps and four 65-step divisions. Reset is synchronous:
// control state and last cord lengths clear, configuration registers return to
// their defaults, no clearing pass.
// ----------------------------------------------------------------------------
module wall_plotter_inverse_kinematics_unit #(
  parameter int MAX_SEGMENTS  = wpik_pkg::MAX_SEGMENTS_DEF,
  parameter int FRACTION_BITS = wpik_pkg::FRACTION_BITS_DEF,
  parameter int QUEUE_DEPTH   = wpik_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  wpik_pkg::item_t                  item,
  output logic                             result_valid,
  input  logic                             result_stall,
  output wpik_pkg::result_t                result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wpik_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                      cfg_data
);
  import wpik_pkg::*;

  cfg_t    cfg;
  job_t    job_in, job_out;
  q_stat_t qstat;
  logic    push, pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lax <= '0;
      cfg.lay <= '0;
      cfg.rax <= 32'(1000 << FRACTION_BITS);
      cfg.ray <= '0;
      cfg.seg <= 31'(1 << FRACTION_BITS);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LEFT_X:  cfg.lax <= cfg_data;
        CFG_LEFT_Y:  cfg.lay <= cfg_data;
        CFG_RIGHT_X: cfg.rax <= cfg_data;
        CFG_RIGHT_Y: cfg.ray <= cfg_data;
        CFG_SEG_LEN: cfg.seg <= cfg_data[30:0];
        default: begin
        end
      endcase
    end
  end

  wpik_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .qstat      (qstat),
    .push       (push),
    .job        (job_in)
  );

  wpik_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (job_in),
    .pop   (pop),
    .rdata (job_out),
    .qstat (qstat)
  );

  wpik_back #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .qstat        (qstat),
    .job          (job_out),
    .pop          (pop),
    .cfg          (cfg),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

FILE: sv/wpik_checker.sv
// ----------------------------------------------------------------------------
// wpik_checker
// Port-level checks of the inverse kinematics unit, bound to the top level.
// ----------------------------------------------------------------------------
module wpik_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input wpik_pkg::result_t result,
  input logic              cfg_valid,
  input logic              cfg_ready
);

  a_rst_result: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result beat valid after reset");

  a_rst_queue: assert property (@(posedge clk) rst |=> !item_stall)
    else $error("input stalled right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

  a_cfg: assert property (@(posedge clk) disable iff (rst) cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind wall_plotter_inverse_kinematics_unit wpik_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready)
);
